// File: sv/shell_command_lexer_assert.svh
// Assertion macros for the shell command lexer.
// Depends on nothing; taken in by the top level with an include.
`ifndef SHELL_COMMAND_LEXER_ASSERT_SVH
`define SHELL_COMMAND_LEXER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SCL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shell_command_lexer: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define SCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shell_command_lexer: next-cycle check failed");

`endif

// File: sv/scl_pkg.sv
// Shared types, token kinds, byte codes and byte classes of the lexer.
// Depends on nothing; used by every lexer module.
`default_nettype none

package scl_pkg;

    localparam logic [3:0] KIND_END        = 4'd0;
    localparam logic [3:0] KIND_DOLLAR     = 4'd1;
    localparam logic [3:0] KIND_ASSIGN     = 4'd2;
    localparam logic [3:0] KIND_DASH       = 4'd3;
    localparam logic [3:0] KIND_REDIRECT   = 4'd4;
    localparam logic [3:0] KIND_QUOTE      = 4'd5;
    localparam logic [3:0] KIND_ESCAPE     = 4'd6;
    localparam logic [3:0] KIND_IDENT      = 4'd7;
    localparam logic [3:0] KIND_PATH       = 4'd8;
    localparam logic [3:0] KIND_UNEXPECTED = 4'd9;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_ASSIGN  = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_DASH    = 8'h2D;

    localparam int QDepth = 4;
    localparam int QAw    = 2;

    typedef struct packed {
        logic [3:0]  kind;
        logic [11:0] start;
        logic [8:0]  length;
        logic        last;
    } t_token;

    typedef struct packed {
        t_token [2:0] tok;
        logic [1:0]   count;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic is_special(input logic [7:0] c);
        return (c == CH_DOLLAR) || (c == CH_ASSIGN) || (c == CH_QUOTE) ||
               (c == CH_GT) || (c == CH_BSLASH);
    endfunction

    function automatic logic is_word_byte(input logic [7:0] c);
        return (c == CH_UNDER) || (c == CH_DASH) ||
               (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_path_byte(input logic [7:0] c, input logic [6:0] floor_v);
        return (c > {1'b0, floor_v}) && !c[7] && !is_special(c);
    endfunction

endpackage

`default_nettype wire

// File: sv/shell_command_lexer.sv
// Top level of the shell command lexer: front, bundle queue and back.
// Depends on scl_pkg, scl_front, scl_queue, scl_back and the assertion header.
//
//  channel   dir  handshake            payload
//  s (byte)  in   i_s_tvalid/o_s_tready  tdata[7:0] ch, tlast line_end
//  m (token) out  o_m_tvalid/i_m_tready  tdata[11:0] start, [20:12] length,
//                                        tuser[3:0] kind, tlast last_token
//  cfg       in   i_cfg_wr_en            wr_data[6:0] printable_floor
//
// A byte is taken every cycle while the four-entry bundle queue has room.
// Each output token goes out on its own beat, so a byte that yields several tokens
// holds the output until each has gone; the output register sets the token rate.
// A byte's first token passes through the queue register, then the output register.
// Reset is synchronous; there is no clearing pass.
// Output stalls fill the queue, then drop o_s_tready until a bundle drains.
`default_nettype none
`include "shell_command_lexer_assert.svh"

module shell_command_lexer #(
    parameter int MAX_TOKEN = 256,
    parameter int MAX_LINE  = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: printable floor
    input  wire logic        i_cfg_wr_en,
    input  wire logic [6:0]  i_cfg_wr_data,
    // byte stream in
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,    // [7:0] ch
    input  wire logic        i_s_tlast,    // line_end
    // token stream out
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,    // [11:0] token_start, [20:12] token_length, pad
    output logic [3:0]       o_m_tuser,    // [3:0] token_kind
    output logic             o_m_tlast     // last_token
);
    import scl_pkg::*;

    logic      w_push, w_pop;
    t_bundle   w_bundle, w_head;
    t_q_status w_qstat;

    // Classify bytes and gather every token a beat produces into one bundle
    scl_front #(
        .MAX_TOKEN (MAX_TOKEN),
        .MAX_LINE  (MAX_LINE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .o_s_tready    (o_s_tready),
        .i_qstat       (w_qstat),
        .o_push        (w_push),
        .o_bundle      (w_bundle)
    );

    // Decouple the byte side from output back-pressure
    scl_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_bundle (w_bundle),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_stat   (w_qstat)
    );

    // Advance through the head bundle one token per beat
    scl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_qstat    (w_qstat),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Never write into a full queue
    `SCL_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, w_push, !w_qstat.full)
    // A pushed bundle always carries at least one token
    `SCL_ASSERT_NOW(a_bundle_not_empty, i_clk, i_rst_n, w_push, w_bundle.count != 2'd0)
    // Only the closing end token carries tlast
    `SCL_ASSERT_NOW(a_last_is_end, i_clk, i_rst_n, o_m_tvalid && o_m_tlast,
                    o_m_tuser == KIND_END)
    // A popped bundle leaves a token in the output register
    `SCL_ASSERT_NEXT(a_pop_fills_output, i_clk, i_rst_n, w_pop, o_m_tvalid)

endmodule

`default_nettype wire

// File: sv/scl_front.sv
// Front part: accepts bytes, classifies them and gathers the tokens of a byte.
// Depends on scl_pkg.
`default_nettype none

module scl_front #(
    parameter int MAX_TOKEN = 256,
    parameter int MAX_LINE  = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [6:0]        i_cfg_wr_data,
    input  wire logic              i_s_tvalid,
    input  wire logic [7:0]        i_s_tdata,
    input  wire logic              i_s_tlast,
    output logic                   o_s_tready,
    input  wire scl_pkg::t_q_status i_qstat,
    output logic                   o_push,
    output scl_pkg::t_bundle       o_bundle
);
    import scl_pkg::*;

    localparam int PosW = $clog2(MAX_LINE);
    localparam int LenW = $clog2(MAX_TOKEN + 1);
    localparam logic [PosW-1:0] LastPos = PosW'(MAX_LINE - 1);
    localparam logic [LenW-1:0] MaxTok  = LenW'(MAX_TOKEN);

    function automatic logic [11:0] to_start(input logic [PosW:0] p);
        logic [PosW+12:0] w;
        w = {12'b0, p};
        return w[11:0];
    endfunction

    function automatic logic [8:0] to_len(input logic [LenW-1:0] l);
        logic [LenW+8:0] w;
        w = {9'b0, l};
        return w[8:0];
    endfunction

    logic [6:0]      r_floor;
    logic [PosW-1:0] r_pos, n_pos;
    logic            r_inq, n_inq;
    logic            r_wopen, n_wopen;
    logic            r_wpath, n_wpath;
    logic            r_wkeep, n_wkeep;
    logic [PosW-1:0] r_wstart, n_wstart;
    logic [LenW-1:0] r_wlen, n_wlen;
    logic            r_esc, n_esc;
    logic            r_dskip, n_dskip;

    logic            w_accept;
    logic [7:0]      c;
    logic            sp, pathb, wordb, spec;
    logic            disp, consume, drop, close_sp;
    logic            cls_v, tok_v, tail_v;
    t_token          cls_t, tok_t, tail_t, end_t;
    logic [PosW-1:0] esc_start;
    logic [PosW:0]   pos_next;
    t_token [2:0]    slots;
    logic [1:0]      cnt;

    assign o_s_tready = !i_qstat.full;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign c          = i_s_tdata;

    always_comb begin
        n_pos    = r_pos;
        n_inq    = r_inq;
        n_wopen  = r_wopen;
        n_wpath  = r_wpath;
        n_wkeep  = r_wkeep;
        n_wstart = r_wstart;
        n_wlen   = r_wlen;
        n_esc    = r_esc;
        n_dskip  = r_dskip;
        sp       = (c == CH_SPACE);
        spec     = is_special(c);
        pathb    = is_path_byte(c, r_floor);
        wordb    = is_word_byte(c);
        disp     = 1'b0;
        consume  = 1'b0;
        drop     = 1'b0;
        close_sp = 1'b0;
        cls_v    = 1'b0;
        tok_v    = 1'b0;
        tail_v   = 1'b0;
        cls_t    = '0;
        tok_t    = '0;
        tail_t   = '0;
        pos_next  = {1'b0, r_pos} + 1'b1;
        esc_start = (r_pos == '0) ? LastPos : r_pos - 1'b1;

        // Pending escape, pending dollar word, open word, else fresh byte
        if (r_esc) begin
            n_esc = 1'b0;
            tok_v = 1'b1;
            if (spec) begin
                tok_t = '{KIND_ESCAPE, to_start({1'b0, esc_start}), 9'd2, 1'b0};
            end else begin
                tok_t = '{KIND_UNEXPECTED, to_start({1'b0, r_pos}), 9'd1, 1'b0};
            end
        end else if (r_dskip) begin
            n_dskip  = 1'b0;
            n_wopen  = 1'b1;
            n_wpath  = 1'b0;
            n_wkeep  = 1'b0;
            n_wstart = r_pos;
            n_wlen   = LenW'(1);
        end else if (r_wopen) begin
            if (c == CH_NUL || spec) begin
                close_sp = 1'b1;
            end else if (r_wpath) begin
                if (pathb) begin
                    consume = 1'b1;
                end else if (sp) begin
                    if (r_wkeep) consume = 1'b1;
                    else close_sp = 1'b1;
                end else begin
                    drop = 1'b1;
                end
            end else begin
                if (wordb) begin
                    consume = 1'b1;
                end else if (sp) begin
                    if (r_wkeep) consume = 1'b1;
                    else close_sp = 1'b1;
                end else if (pathb) begin
                    n_wpath = 1'b1;
                    consume = 1'b1;
                end else begin
                    drop = 1'b1;
                end
            end
            if (close_sp) begin
                cls_v   = 1'b1;
                n_wopen = 1'b0;
                disp    = 1'b1;
            end
            if (drop) begin
                n_wopen = 1'b0;
                tok_v   = 1'b1;
                tok_t   = '{KIND_UNEXPECTED, to_start({1'b0, r_pos}), 9'd1, 1'b0};
            end
            if (consume) begin
                n_wlen = r_wlen + 1'b1;
                // Cut the word once it reaches the limit
                if (n_wlen == MaxTok) begin
                    cls_v   = 1'b1;
                    n_wopen = 1'b0;
                end
            end
            cls_t = '{(n_wpath ? KIND_PATH : KIND_IDENT), to_start({1'b0, r_wstart}),
                      to_len(n_wlen), 1'b0};
        end else begin
            disp = 1'b1;
        end

        if (disp) begin
            if (r_inq) begin
                if (c == CH_QUOTE) begin
                    tok_v = 1'b1;
                    tok_t = '{KIND_QUOTE, to_start({1'b0, r_pos}), 9'd1, 1'b0};
                    n_inq = 1'b0;
                end else if (c == CH_DOLLAR) begin
                    tok_v   = 1'b1;
                    tok_t   = '{KIND_DOLLAR, to_start({1'b0, r_pos}), 9'd1, 1'b0};
                    n_dskip = 1'b1;
                end else if (c == CH_BSLASH) begin
                    n_esc = 1'b1;
                end else begin
                    n_wopen  = 1'b1;
                    n_wpath  = 1'b0;
                    n_wkeep  = 1'b1;
                    n_wstart = r_pos;
                    n_wlen   = LenW'(1);
                end
            end else begin
                unique case (c)
                    CH_SPACE: ;
                    CH_NUL: begin
                        tok_v = 1'b1;
                        tok_t = '{KIND_END, to_start(pos_next), 9'd0, 1'b0};
                    end
                    CH_DOLLAR: begin
                        tok_v = 1'b1;
                        tok_t = '{KIND_DOLLAR, to_start({1'b0, r_pos}), 9'd1, 1'b0};
                    end
                    CH_ASSIGN: begin
                        tok_v = 1'b1;
                        tok_t = '{KIND_ASSIGN, to_start({1'b0, r_pos}), 9'd1, 1'b0};
                    end
                    CH_DASH: begin
                        tok_v = 1'b1;
                        tok_t = '{KIND_DASH, to_start({1'b0, r_pos}), 9'd1, 1'b0};
                    end
                    CH_GT: begin
                        tok_v = 1'b1;
                        tok_t = '{KIND_REDIRECT, to_start({1'b0, r_pos}), 9'd1, 1'b0};
                    end
                    CH_QUOTE: begin
                        tok_v = 1'b1;
                        tok_t = '{KIND_QUOTE, to_start({1'b0, r_pos}), 9'd1, 1'b0};
                        n_inq = 1'b1;
                    end
                    CH_BSLASH: n_esc = 1'b1;
                    default: begin
                        n_wopen  = 1'b1;
                        n_wpath  = 1'b0;
                        n_wkeep  = 1'b0;
                        n_wstart = r_pos;
                        n_wlen   = LenW'(1);
                    end
                endcase
            end
        end

        n_pos = (r_pos == LastPos) ? '0 : pos_next[PosW-1:0];

        // Line end: flush a dangling escape or open word, then close the line
        end_t = '{KIND_END, to_start(pos_next), 9'd0, 1'b1};
        if (i_s_tlast) begin
            if (n_esc) begin
                tail_v = 1'b1;
                tail_t = '{KIND_UNEXPECTED, to_start({1'b0, r_pos}), 9'd1, 1'b0};
            end else if (n_wopen) begin
                tail_v = 1'b1;
                tail_t = '{(n_wpath ? KIND_PATH : KIND_IDENT), to_start({1'b0, n_wstart}),
                           to_len(n_wlen), 1'b0};
            end
            n_pos    = '0;
            n_inq    = 1'b0;
            n_wopen  = 1'b0;
            n_wpath  = 1'b0;
            n_wkeep  = 1'b0;
            n_wstart = '0;
            n_wlen   = '0;
            n_esc    = 1'b0;
            n_dskip  = 1'b0;
        end

        // Pack the tokens in order
        slots = '0;
        cnt   = 2'd0;
        if (cls_v) begin
            slots[0] = cls_t;
            cnt      = 2'd1;
        end
        if (tok_v) begin
            slots[cnt] = tok_t;
            cnt        = cnt + 2'd1;
        end
        if (tail_v && cnt != 2'd3) begin
            slots[cnt] = tail_t;
            cnt        = cnt + 2'd1;
        end
        if (i_s_tlast && cnt != 2'd3) begin
            slots[cnt] = end_t;
            cnt        = cnt + 2'd1;
        end
    end

    assign o_push         = w_accept && (cnt != 2'd0);
    assign o_bundle.tok   = slots;
    assign o_bundle.count = cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor  <= 7'd32;
            r_pos    <= '0;
            r_inq    <= 1'b0;
            r_wopen  <= 1'b0;
            r_wpath  <= 1'b0;
            r_wkeep  <= 1'b0;
            r_wstart <= '0;
            r_wlen   <= '0;
            r_esc    <= 1'b0;
            r_dskip  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_floor <= i_cfg_wr_data;
            if (w_accept) begin
                r_pos    <= n_pos;
                r_inq    <= n_inq;
                r_wopen  <= n_wopen;
                r_wpath  <= n_wpath;
                r_wkeep  <= n_wkeep;
                r_wstart <= n_wstart;
                r_wlen   <= n_wlen;
                r_esc    <= n_esc;
                r_dskip  <= n_dskip;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/scl_queue.sv
// Short queue of token bundles between the front and back parts.
// Depends on scl_pkg.
`default_nettype none

module scl_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire scl_pkg::t_bundle  i_bundle,
    input  wire logic              i_pop,
    output scl_pkg::t_bundle       o_head,
    output scl_pkg::t_q_status     o_stat
);
    import scl_pkg::*;

    t_bundle        r_mem [QDepth];
    logic [QAw-1:0] r_wp, r_rp;
    logic [QAw:0]   r_cnt;
    logic           w_pop;

    assign w_pop        = i_pop && (r_cnt != '0);
    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (QAw + 1)'(QDepth));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !w_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && w_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    // Hold payload without reset
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_bundle;
    end

endmodule

`default_nettype wire

// File: sv/scl_back.sv
// Back part: walks the tokens of the head bundle onto the output register.
// Depends on scl_pkg.
`default_nettype none

module scl_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire scl_pkg::t_bundle  i_head,
    input  wire scl_pkg::t_q_status i_qstat,
    output logic                   o_pop,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [23:0]            o_m_tdata,
    output logic [3:0]             o_m_tuser,
    output logic                   o_m_tlast
);
    import scl_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    t_token     r_tok;
    logic       w_load, w_final;

    assign w_load  = !i_qstat.empty && (!r_valid || i_m_tready);
    assign w_final = (r_idx == i_head.count - 2'd1);
    assign o_pop   = w_load && w_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_final ? 2'd0 : r_idx + 2'd1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_tok <= i_head.tok[r_idx];
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {3'b000, r_tok.length, r_tok.start};
    assign o_m_tuser  = r_tok.kind;
    assign o_m_tlast  = r_tok.last;

endmodule

`default_nettype wire

// File: sim/tb_shell_command_lexer.sv
`timescale 1ns / 100ps
// Self-checking bench for shell_command_lexer: command-line bytes in, tokens out.
// Depends on scl_pkg (token kinds, byte codes, token struct) and the lexer RTL.

module tb_shell_command_lexer;
    import scl_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int HOLD_CYCLES = 300;
    localparam int LONG_LINE   = 45;
    localparam string PATH_CHARS = "/.:~+@%,#";
    localparam logic [7:0] OP_BYTES [5] = '{CH_DOLLAR, CH_ASSIGN, CH_QUOTE, CH_GT, CH_BSLASH};

    // Token predictor and store of tokens still due from the lexer.
    class token_ledger;
        logic [6:0]  floor_v;
        logic [11:0] pos;
        logic [11:0] wstart;
        int unsigned wlen;
        bit quoted, in_word, word_path, word_spaces, esc_wait, dollar_wait;
        t_token due_tokens[$];
        int unsigned errors, bytes_seen, lines_seen, tokens_seen;
        int unsigned kind_hits[10];

        function new();
            floor_v = 7'd32;
            clear_line();
        endfunction

        function void clear_line();
            pos = '0;
            wstart = '0;
            wlen = 0;
            quoted = 0;
            in_word = 0;
            word_path = 0;
            word_spaces = 0;
            esc_wait = 0;
            dollar_wait = 0;
        endfunction

        function bit is_op_byte(logic [7:0] c);
            return c == CH_DOLLAR || c == CH_ASSIGN || c == CH_QUOTE || c == CH_GT ||
                   c == CH_BSLASH;
        endfunction

        function bit is_ident_byte(logic [7:0] c);
            return c == CH_UNDER || c == CH_DASH || (c >= "a" && c <= "z") ||
                   (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
        endfunction

        function bit is_path_char(logic [7:0] c);
            return c > {1'b0, floor_v} && c < 8'd128 && !is_op_byte(c);
        endfunction

        function void emit(logic [3:0] k, logic [11:0] s, int unsigned len, bit l);
            t_token tok;
            tok.kind = k;
            tok.start = s;
            tok.length = len[8:0];
            tok.last = l;
            due_tokens = {due_tokens, tok};
        endfunction

        function void start_word(logic [11:0] p, bit keeps);
            in_word = 1;
            word_path = 0;
            word_spaces = keeps;
            wstart = p;
            wlen = 1;
        endfunction

        function void close_word();
            emit(word_path ? KIND_PATH : KIND_IDENT, wstart, wlen, 1'b0);
            in_word = 0;
        endfunction

        // Returns 1 when the open word swallows the byte.
        function bit word_take(logic [7:0] c, logic [11:0] p);
            if (c == CH_NUL || is_op_byte(c)) begin
                close_word();
                return 0;
            end
            if (word_path) begin
                if (!is_path_char(c)) begin
                    if (c == CH_SPACE) begin
                        if (!word_spaces) begin
                            close_word();
                            return 0;
                        end
                    end else begin
                        // stray control byte: drop the word, flag the byte
                        in_word = 0;
                        emit(KIND_UNEXPECTED, p, 1, 1'b0);
                        return 1;
                    end
                end
            end else if (!is_ident_byte(c)) begin
                if (c == CH_SPACE) begin
                    if (!word_spaces) begin
                        close_word();
                        return 0;
                    end
                end else if (is_path_char(c)) begin
                    word_path = 1;
                end else begin
                    in_word = 0;
                    emit(KIND_UNEXPECTED, p, 1, 1'b0);
                    return 1;
                end
            end
            wlen++;
            if (wlen >= 256) close_word();
            return 1;
        endfunction

        function void dispatch(logic [7:0] c, logic [11:0] p);
            if (quoted) begin
                if (c == CH_QUOTE) begin
                    emit(KIND_QUOTE, p, 1, 1'b0);
                    quoted = 0;
                end else if (c == CH_DOLLAR) begin
                    emit(KIND_DOLLAR, p, 1, 1'b0);
                    dollar_wait = 1;
                end else if (c == CH_BSLASH) begin
                    esc_wait = 1;
                end else begin
                    start_word(p, 1'b1);
                end
                return;
            end
            case (c)
                CH_SPACE: ;
                CH_NUL: emit(KIND_END, p + 12'd1, 0, 1'b0);
                CH_DOLLAR: emit(KIND_DOLLAR, p, 1, 1'b0);
                CH_ASSIGN: emit(KIND_ASSIGN, p, 1, 1'b0);
                CH_DASH: emit(KIND_DASH, p, 1, 1'b0);
                CH_GT: emit(KIND_REDIRECT, p, 1, 1'b0);
                CH_QUOTE: begin
                    emit(KIND_QUOTE, p, 1, 1'b0);
                    quoted = 1;
                end
                CH_BSLASH: esc_wait = 1;
                default: start_word(p, 1'b0);
            endcase
        endfunction

        // Note one accepted byte and queue the tokens it completes.
        function void take_byte(logic [7:0] c, bit eol);
            logic [11:0] p;
            p = pos;
            bytes_seen++;
            if (esc_wait) begin
                esc_wait = 0;
                if (is_op_byte(c)) emit(KIND_ESCAPE, p - 12'd1, 2, 1'b0);
                else emit(KIND_UNEXPECTED, p, 1, 1'b0);
            end else if (dollar_wait) begin
                dollar_wait = 0;
                start_word(p, 1'b0);
            end else if (!in_word) begin
                dispatch(c, p);
            end else if (!word_take(c, p)) begin
                dispatch(c, p);
            end
            pos = p + 12'd1;
            if (eol) begin
                if (esc_wait) emit(KIND_UNEXPECTED, p, 1, 1'b0);
                else if (in_word) close_word();
                emit(KIND_END, p + 12'd1, 0, 1'b1);
                lines_seen++;
                clear_line();
            end
        endfunction

        function void match_token(logic [3:0] k, logic [11:0] s, logic [8:0] len, logic l);
            t_token want;
            if (due_tokens.size() == 0) begin
                $error("token with nothing due: kind %0d start %0d length %0d", k, s, len);
                errors++;
                return;
            end
            want = due_tokens.pop_front();
            tokens_seen++;
            if (k !== want.kind) begin
                $error("token_kind: expected %0d, got %0d", want.kind, k);
                errors++;
            end
            if (s !== want.start) begin
                $error("token_start: expected %0d, got %0d", want.start, s);
                errors++;
            end
            if (len !== want.length) begin
                $error("token_length: expected %0d, got %0d", want.length, len);
                errors++;
            end
            if (l !== want.last) begin
                $error("last_token: expected %0d, got %0d", want.last, l);
                errors++;
            end
            if (want.kind < 4'd10) kind_hits[want.kind]++;
        endfunction
    endclass

    logic        i_clk;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [6:0]  cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [23:0] o_m_tdata;
    logic [3:0]  o_m_tuser;
    logic        o_m_tlast;

    token_ledger ledger = new();
    logic [7:0]  line_buf[$];
    int          src_idle_pct = 13;
    int          dst_idle_pct = 56;
    bit          hold_request = 0;
    int          cycle_count = 0;

    shell_command_lexer DUT (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_s_tvalid   (s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (s_tdata),     // [7:0] ch
        .i_s_tlast    (s_tlast),     // line_end
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (m_tready),
        .o_m_tdata    (o_m_tdata),   // [11:0] token_start, [20:12] token_length, pad
        .o_m_tuser    (o_m_tuser),   // [3:0] token_kind
        .o_m_tlast    (o_m_tlast)    // last_token
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the lexer wedges or loses tokens.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Token sink: drive tready at the falling edge. A hold request freezes the
    // sink for a long stretch so the internal queue fills and backs up the input.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left = HOLD_CYCLES;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
            end
        end
    end

    // Check every token beat against the oldest prediction.
    always @(posedge i_clk) begin
        if (rst_n && o_m_tvalid && m_tready)
            ledger.match_token(o_m_tuser, o_m_tdata[11:0], o_m_tdata[20:12], o_m_tlast);
    end

    // Add one byte to the line being built.
    function automatic void append_byte(input logic [7:0] b);
        line_buf = {line_buf, b};
    endfunction

    // Offer one byte from a falling edge; return at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] ch, input logic eol);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        s_tlast <= eol;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        ledger.take_byte(ch, eol);
        @(negedge i_clk);
    endtask

    // Send line_buf as one line; the final byte carries the line end.
    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_byte(line_buf[i], i == line_buf.size() - 1);
    endtask

    task automatic send_text(input string txt);
        line_buf.delete();
        for (int i = 0; i < txt.len(); i++) append_byte(txt[i]);
        send_line();
    endtask

    // Drop valid and wait for every due token, then let the pipeline settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (ledger.due_tokens.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Register writes happen only with the lexer idle.
    task automatic write_floor(input logic [6:0] v);
        drain();
        cfg_wr_data <= v;
        cfg_wr_en <= 1'b1;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        ledger.floor_v = v;
    endtask

    function automatic logic [7:0] rand_ident_byte();
        int unsigned r;
        r = $urandom_range(0, 63);
        if (r < 26) return 8'(8'h61 + r);
        if (r < 52) return 8'(8'h41 + r - 26);
        if (r < 62) return 8'(8'h30 + r - 52);
        return (r == 62) ? CH_UNDER : CH_DASH;
    endfunction

    function automatic void add_word(input bit pathy);
        int unsigned n;
        n = $urandom_range(1, 8);
        repeat (n) begin
            if (pathy && $urandom_range(0, 2) == 0)
                append_byte(PATH_CHARS[$urandom_range(0, PATH_CHARS.len() - 1)]);
            else
                append_byte(rand_ident_byte());
        end
    endfunction

    // Append one lexical chunk: mostly well-formed pieces, some noise.
    function automatic void add_chunk();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 99);
        if (r < 28) begin
            add_word(1'b0);
        end else if (r < 40) begin
            add_word(1'b1);
        end else if (r < 50) begin
            case ($urandom_range(0, 3))
                0: append_byte(CH_DOLLAR);
                1: append_byte(CH_ASSIGN);
                2: append_byte(CH_DASH);
                default: append_byte(CH_GT);
            endcase
        end else if (r < 62) begin
            // quoted run; now and then left open
            append_byte(CH_QUOTE);
            n = $urandom_range(1, 3);
            repeat (n) begin
                case ($urandom_range(0, 3))
                    0: add_word(1'b0);
                    1: add_word(1'b1);
                    2: begin
                        append_byte(CH_DOLLAR);
                        add_word(1'b0);
                    end
                    default: append_byte(CH_SPACE);
                endcase
            end
            if ($urandom_range(0, 9) != 0) append_byte(CH_QUOTE);
        end else if (r < 70) begin
            append_byte(CH_BSLASH);
            append_byte(OP_BYTES[$urandom_range(0, 4)]);
        end else if (r < 84) begin
            append_byte(CH_SPACE);
        end else if (r < 93) begin
            append_byte(8'($urandom_range(0, 255)));
        end else begin
            // escape of an arbitrary byte, usually a bad one
            append_byte(CH_BSLASH);
            append_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 2) != 0) append_byte(CH_SPACE);
    endfunction

    // Build a random line, sometimes ending on a dangling escape, dollar or quote.
    function automatic void compose_line(input int unsigned target);
        line_buf.delete();
        while (line_buf.size() < target) add_chunk();
        case ($urandom_range(0, 19))
            0: append_byte(CH_BSLASH);
            1: begin
                append_byte(CH_QUOTE);
                append_byte(CH_DOLLAR);
            end
            2: begin
                append_byte(CH_QUOTE);
                add_word(1'b0);
            end
            default: ;
        endcase
    endfunction

    task automatic random_lines(input int unsigned byte_goal);
        while (ledger.bytes_seen < byte_goal) begin
            compose_line($urandom_range(1, 16));
            send_line();
        end
    endtask

    initial begin
        logic [6:0] mid_floor;
        mid_floor = 7'($urandom_range(1, 126));
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // Phase one: busy sender, sparse sink. Directed lines first.
        src_idle_pct = 13;
        dst_idle_pct = 56;
        write_floor(7'd32);
        send_text("x=-1 >a/b");          // plain operators but dollar, identifiers, a path
        send_text("'p q$r s'");          // spaces join, dollar word inside quotes
        send_text("\\$\\q");             // good escape, then a bad one
        // control byte inside a word, zero byte outside quotes, top byte,
        // backslash as the last byte of the line
        line_buf = '{8'h61, 8'h01, CH_NUL, 8'hFF, CH_BSLASH};
        send_line();
        send_text("'$");                 // dollar at line end in an unclosed quote
        write_floor(7'd0);
        random_lines(75);

        // Phase two: the other way round, floor at its top.
        src_idle_pct = 56;
        dst_idle_pct = 13;
        write_floor(7'd127);
        random_lines(140);

        // Phase three: no idling, a mid-range floor.
        src_idle_pct = 0;
        dst_idle_pct = 0;
        write_floor(mid_floor);
        random_lines(205);

        // Back-pressure line: the sink holds off at the start, so the queue
        // fills and the input stalls while bytes keep coming.
        drain();
        line_buf.delete();
        while (line_buf.size() < LONG_LINE) add_chunk();
        hold_request = 1;
        send_line();

        drain();
        $display("Run covered %0d bytes in %0d lines, %0d tokens checked, %0d errors.",
                 ledger.bytes_seen, ledger.lines_seen, ledger.tokens_seen, ledger.errors);
        $display("Token kinds end..unexpected: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                 ledger.kind_hits[0], ledger.kind_hits[1], ledger.kind_hits[2],
                 ledger.kind_hits[3], ledger.kind_hits[4], ledger.kind_hits[5],
                 ledger.kind_hits[6], ledger.kind_hits[7], ledger.kind_hits[8],
                 ledger.kind_hits[9]);
        if (ledger.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
